// ----- hdl/swq_pkg.sv -----
`default_nettype none

package swq_pkg;

    // Fixed field widths of the request and result beats.
    localparam int TICK_W      = 63;
    localparam int WT_W        = 64;
    localparam int DUR_W       = 32;
    localparam int REQ_ID_W    = 8;
    localparam int ID_MAX_BITS = 16;

    // At most this many wake results leave for one tick.
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Request type codes.
    localparam logic REQ_SLEEP = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Result kind codes.
    localparam logic RES_WOKEN  = 1'b0;
    localparam logic RES_REJECT = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [REQ_ID_W-1:0] requester_id;
        logic [DUR_W-1:0]    sleep_duration;
    } t_req;

    typedef struct packed {
        logic                result_kind;
        logic [REQ_ID_W-1:0] woken_id;
        logic [TICK_W-1:0]   tick_now;
        logic                last_result;
    } t_res;

endpackage

`default_nettype wire

// ----- hdl/sleep_wakeup_timer_queue_top.sv -----
`default_nettype none

// Sleep and wakeup timer queue. A request beat is either a sleep request
// (requester id and duration) or one timer tick. Sleepers are kept in a
// circular table sorted by wake time, equal times in arrival order. A sleep
// request gives no result unless the table is full, in which case one
// rejected result follows. A tick advances the 63-bit count and gives one
// wake result per due head entry (at most 16 per tick), the final one marked
// last. The block takes one request at a time and is not ready meanwhile.
// A sleep insert walks the table from the tail: each entry it moves is first
// read through the registered memory port, then compared in the shared
// 64-bit comparator and written one slot up. The result side can stall a
// tick or a rejected sleep. The table needs no clearing after reset.
module sleep_wakeup_timer_queue_top
    import swq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ICHK,
        ST_ICMP,
        ST_TCHK,
        ST_TCMP,
        ST_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [WT_W-1:0]     r_key, n_key;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic [OW-1:0]       r_occ, n_occ;
    logic [AW-1:0]       r_head, n_head;
    logic [OW-1:0]       r_j, n_j;
    logic [AW-1:0]       r_addr, n_addr;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_pend_v, n_pend_v;
    logic                r_pend_kind, n_pend_kind;
    logic [ID_BITS-1:0]  r_pend_id, n_pend_id;
    logic                r_out_valid, n_out_valid;
    t_res                r_out, n_out;

    logic                w_en;
    logic [AW-1:0]       w_addr;
    logic [WT_W-1:0]     w_wt;
    logic [ID_BITS-1:0]  w_id;
    logic [WT_W-1:0]     q_wt;
    logic [ID_BITS-1:0]  q_id;
    logic                cmp_le;
    logic                out_free;
    logic [ID_MAX_BITS-1:0] req_id_ext;
    logic [ID_MAX_BITS-1:0] pend_id_ext;

    // Table slot for an offset from the head, wrapping at the depth.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [OW-1:0] ofs);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(ofs);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    swq_store #(
        .DEPTH(QUEUE_DEPTH),
        .IDW  (ID_BITS),
        .AW   (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (w_en),
        .i_wr_addr(w_addr),
        .i_wr_wt  (w_wt),
        .i_wr_id  (w_id),
        .i_rd_addr(n_addr),
        .o_rd_wt  (q_wt),
        .o_rd_id  (q_id)
    );

    swq_cmp u_cmp (
        .i_entry(q_wt),
        .i_key  (r_key),
        .o_le   (cmp_le)
    );

    // Id width adaption between the beat fields and the table.
    always_comb begin
        req_id_ext = '0;
        req_id_ext[REQ_ID_W-1:0] = i_req.requester_id;
        pend_id_ext = '0;
        pend_id_ext[ID_BITS-1:0] = r_pend_id;
    end

    assign out_free    = !r_out_valid || i_res_ready;
    assign o_req_ready = (r_state == ST_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_key       = r_key;
        n_id        = r_id;
        n_occ       = r_occ;
        n_head      = r_head;
        n_j         = r_j;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_pend_v    = r_pend_v;
        n_pend_kind = r_pend_kind;
        n_pend_id   = r_pend_id;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        w_en        = 1'b0;
        w_addr      = slot(r_head, r_j);
        w_wt        = r_key;
        w_id        = r_id;

        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.req_type == REQ_TICK) begin
                        n_tick   = r_tick + 1'b1;
                        n_key    = {1'b0, n_tick};
                        n_cnt    = '0;
                        n_pend_v = 1'b0;
                        n_state  = ST_TCHK;
                    end else if (r_occ == OW'(QUEUE_DEPTH)) begin
                        n_pend_kind = RES_REJECT;
                        n_pend_id   = req_id_ext[ID_BITS-1:0];
                        n_pend_v    = 1'b1;
                        n_state     = ST_EMIT;
                    end else begin
                        n_key   = {1'b0, r_tick} + {{(WT_W-DUR_W){1'b0}},
                                                    i_req.sleep_duration};
                        n_id    = req_id_ext[ID_BITS-1:0];
                        n_j     = r_occ;
                        n_state = ST_ICHK;
                    end
                end
            end

            // Insert: read the entry just below the hole, or place the new entry at the head.
            ST_ICHK: begin
                if (r_j == '0) begin
                    w_en    = 1'b1;
                    n_occ   = r_occ + 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_addr  = slot(r_head, r_j - 1'b1);
                    n_state = ST_ICMP;
                end
            end

            // Insert: place the new entry or move the read one up.
            ST_ICMP: begin
                w_en = 1'b1;
                if (cmp_le) begin
                    n_occ   = r_occ + 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    w_wt    = q_wt;
                    w_id    = q_id;
                    n_j     = r_j - 1'b1;
                    n_state = ST_ICHK;
                end
            end

            // Tick: read the head unless the run is over.
            ST_TCHK: begin
                if (r_occ == '0 || r_cnt == CNT_W'(MAX_RESULTS)) begin
                    n_state = r_pend_v ? ST_EMIT : ST_IDLE;
                end else begin
                    n_addr  = r_head;
                    n_state = ST_TCMP;
                end
            end

            // Tick: pop a due head, sending the one before it as not last; end at a head not due.
            ST_TCMP: begin
                if (cmp_le) begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            n_out_valid       = 1'b1;
                            n_out.result_kind = r_pend_kind;
                            n_out.woken_id    = pend_id_ext[REQ_ID_W-1:0];
                            n_out.tick_now    = r_tick;
                            n_out.last_result = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_kind = RES_WOKEN;
                        n_pend_id   = q_id;
                        n_head      = slot(r_head, OW'(1));
                        n_occ       = r_occ - 1'b1;
                        n_cnt       = r_cnt + 1'b1;
                        n_state     = ST_TCHK;
                    end
                end else begin
                    n_state = r_pend_v ? ST_EMIT : ST_IDLE;
                end
            end

            // Send the final result of the item with the last mark.
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_kind = r_pend_kind;
                    n_out.woken_id    = pend_id_ext[REQ_ID_W-1:0];
                    n_out.tick_now    = r_tick;
                    n_out.last_result = 1'b1;
                    n_pend_v          = 1'b0;
                    n_state           = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tick      <= '0;
            r_occ       <= '0;
            r_head      <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_occ       <= n_occ;
            r_head      <= n_head;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
        r_key       <= n_key;
        r_id        <= n_id;
        r_j         <= n_j;
        r_addr      <= n_addr;
        r_cnt       <= n_cnt;
        r_pend_kind <= n_pend_kind;
        r_pend_id   <= n_pend_id;
        r_out       <= n_out;
    end

endmodule

`default_nettype wire

// ----- hdl/swq_cmp.sv -----
`default_nettype none

// Shared wake time comparator: flags an entry whose wake time is at or
// below the key (the new count on a tick, the new wake time on an insert).
module swq_cmp
    import swq_pkg::*;
(
    input  wire logic [WT_W-1:0] i_entry,
    input  wire logic [WT_W-1:0] i_key,
    output logic                 o_le
);

    assign o_le = (i_entry <= i_key);

endmodule

`default_nettype wire

// ----- hdl/swq_store.sv -----
`default_nettype none

// Entry table: one write port and one read port with registered data.
module swq_store
    import swq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDW   = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire logic [WT_W-1:0] i_wr_wt,
    input  wire logic [IDW-1:0]  i_wr_id,
    input  wire logic [AW-1:0]   i_rd_addr,
    output logic      [WT_W-1:0] o_rd_wt,
    output logic      [IDW-1:0]  o_rd_id
);

    logic [WT_W-1:0] r_mem_wt [DEPTH];
    logic [IDW-1:0]  r_mem_id [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_wt[i_wr_addr] <= i_wr_wt;
            r_mem_id[i_wr_addr] <= i_wr_id;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rd_wt <= r_mem_wt[i_rd_addr];
        o_rd_id <= r_mem_id[i_rd_addr];
    end

endmodule

`default_nettype wire
